[sv/length_prefixed_frame_encoder_core_defines.svh]
// Assertion macros shared by the frame encoder RTL.
`ifndef LENGTH_PREFIXED_FRAME_ENCODER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_ENCODER_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define LPFE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lpfe: invariant violated");

// Consequent must hold on the edge after the antecedent.
`define LPFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpfe: sequence violated");

`endif

[sv/lpfe_pkg.sv]
// Shared types and constants for the length-prefixed frame encoder.
package lpfe_pkg;

  localparam int LENGTH_WIDTH_DEFAULT = 64;
  localparam int FRAME_LENGTH_W       = 64;
  localparam int LEN_BYTES            = 8;
  localparam int STEP_W               = $clog2(LEN_BYTES + 1);
  localparam int QUEUE_DEPTH          = 2;
  localparam int QUEUE_PTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [7:0] FLAG_SHORT = 8'h00;
  localparam logic [7:0] FLAG_LONG  = 8'h02;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BUSY = 2'd1;
  localparam logic [1:0] ERR_IDLE = 2'd2;

  typedef enum logic [2:0] {
    CMD_LONG_HDR,
    CMD_SHORT_HDR,
    CMD_DATA,
    CMD_ERR_BUSY,
    CMD_ERR_IDLE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [FRAME_LENGTH_W-1:0] len;
    logic [7:0]                data;
    logic                      fend;
  } lpfe_cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic [1:0] error_code;
  } lpfe_result_t;

  typedef struct packed {
    logic      push;
    lpfe_cmd_t cmd;
  } lpfe_push_t;

endpackage

[sv/lpfe_in_if.sv]
// Input channel: start and data items.
interface lpfe_in_if;
  import lpfe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [FRAME_LENGTH_W-1:0] frame_length;
  logic [7:0]                body_byte;

  modport source (output valid, opcode, frame_length, body_byte, input ready);
  modport sink   (input valid, opcode, frame_length, body_byte, output ready);
endinterface

[sv/lpfe_out_if.sv]
// Output channel: encoded byte stream items.
interface lpfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;
  logic [1:0] error_code;

  modport source (output valid, out_byte, run_last, frame_end, error_code, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, error_code, output ready);
endinterface

[sv/lpfe_front.sv]
// Front end: accepts items, tracks frame state, classifies into commands.
`include "length_prefixed_frame_encoder_core_defines.svh"

module lpfe_front #(
  parameter int LENGTH_WIDTH = lpfe_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  lpfe_in_if.sink              req,
  input  logic                 full,
  output lpfe_pkg::lpfe_push_t push_req
);
  import lpfe_pkg::*;

  logic                    busy;
  logic                    busy_next;
  logic [LENGTH_WIDTH-1:0] remaining;
  logic [LENGTH_WIDTH-1:0] remaining_next;
  logic [LENGTH_WIDTH-1:0] len;
  logic [LENGTH_WIDTH-1:0] rem_dec;
  logic                    accept;
  lpfe_cmd_t               cmd;

  assign req.ready = !full && !rst;
  assign accept    = req.valid && req.ready;
  assign len       = req.frame_length[LENGTH_WIDTH-1:0];
  assign rem_dec   = remaining - LENGTH_WIDTH'(1);

  always_comb begin
    busy_next      = busy;
    remaining_next = remaining;
    cmd.kind       = CMD_ERR_BUSY;
    cmd.len        = FRAME_LENGTH_W'(len);
    cmd.data       = req.body_byte;
    cmd.fend       = 1'b0;
    if (req.opcode == OP_START) begin
      if (busy) begin
        cmd.kind = CMD_ERR_BUSY;
      end else begin
        cmd.kind       = (|len[LENGTH_WIDTH-1:8]) ? CMD_LONG_HDR : CMD_SHORT_HDR;
        cmd.fend       = (len == '0);
        remaining_next = len;
        busy_next      = (len != '0);
      end
    end else begin
      if (!busy) begin
        cmd.kind = CMD_ERR_IDLE;
      end else begin
        cmd.kind       = CMD_DATA;
        cmd.fend       = (rem_dec == '0);
        remaining_next = rem_dec;
        busy_next      = (rem_dec != '0);
      end
    end
  end

  assign push_req.push = accept;
  assign push_req.cmd  = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (accept) begin
      busy      <= busy_next;
      remaining <= remaining_next;
    end
  end

  `LPFE_ASSERT_ALWAYS(a_busy_has_bytes, !busy || (remaining != '0))
  `LPFE_ASSERT_ALWAYS(a_idle_no_bytes, busy || (remaining == '0))
  `LPFE_ASSERT_NEXT(a_last_data_closes, accept && (req.opcode == OP_DATA) && busy && (remaining == LENGTH_WIDTH'(1)), !busy)

endmodule

[sv/lpfe_queue.sv]
// Short command queue between front and back.
`include "length_prefixed_frame_encoder_core_defines.svh"

module lpfe_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  lpfe_pkg::lpfe_push_t push_req,
  output logic                 full,
  output logic                 head_valid,
  output lpfe_pkg::lpfe_cmd_t  head,
  input  logic                 pop
);
  import lpfe_pkg::*;

  lpfe_cmd_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push_req.push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    ptr_inc = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  `LPFE_ASSERT_ALWAYS(a_count_bound, count <= QUEUE_CNT_W'(QUEUE_DEPTH))
  `LPFE_ASSERT_NEXT(a_push_fills, do_push && !do_pop, head_valid)
  `LPFE_ASSERT_NEXT(a_pop_frees, do_pop && !do_push, !full)

endmodule

[sv/lpfe_back.sv]
// Back end: expands commands into header and body bytes, output register.
`include "length_prefixed_frame_encoder_core_defines.svh"

module lpfe_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  lpfe_pkg::lpfe_cmd_t head,
  output logic                pop,
  lpfe_out_if.source          rsp
);
  import lpfe_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [2:0]        sel;
  logic              emit;
  logic              out_valid;
  lpfe_result_t      out_item;
  lpfe_result_t      res;

  // Length bytes go out most significant first: step 1 -> byte 7.
  assign sel = 3'(STEP_W'(LEN_BYTES) - step);

  always_comb begin
    res.out_byte   = 8'h00;
    res.run_last   = 1'b1;
    res.frame_end  = 1'b0;
    res.error_code = ERR_NONE;
    case (head.kind)
      CMD_LONG_HDR: begin
        res.out_byte = (step == '0) ? FLAG_LONG : head.len[{sel, 3'b000} +: 8];
        res.run_last = (step == STEP_W'(LEN_BYTES));
      end
      CMD_SHORT_HDR: begin
        res.out_byte  = (step == '0) ? FLAG_SHORT : head.len[7:0];
        res.run_last  = (step != '0);
        res.frame_end = (step != '0) && head.fend;
      end
      CMD_DATA: begin
        res.out_byte  = head.data;
        res.frame_end = head.fend;
      end
      CMD_ERR_BUSY: res.error_code = ERR_BUSY;
      CMD_ERR_IDLE: res.error_code = ERR_IDLE;
      default:      res.error_code = ERR_NONE;
    endcase
  end

  assign emit      = head_valid && (!out_valid || rsp.ready);
  assign pop       = emit && res.run_last;
  assign step_next = res.run_last ? '0 : step + STEP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        step <= step_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.out_byte   = out_item.out_byte;
  assign rsp.run_last   = out_item.run_last;
  assign rsp.frame_end  = out_item.frame_end;
  assign rsp.error_code = out_item.error_code;

  `LPFE_ASSERT_ALWAYS(a_step_bound, step <= STEP_W'(LEN_BYTES))
  `LPFE_ASSERT_ALWAYS(a_run_has_head, (step == '0) || head_valid)
  `LPFE_ASSERT_ALWAYS(a_err_single, !rsp.valid || (rsp.error_code == ERR_NONE) || (rsp.run_last && !rsp.frame_end))

endmodule

[sv/length_prefixed_frame_encoder_core.sv]
// Length-prefixed frame encoder. A start item (opcode 0) opens a frame and
// produces a header: flags 0x00 plus a one-byte length when the length fits
// in a byte, else flags 0x02 plus the length as eight big-endian bytes. Each
// data item (opcode 1) passes one body byte through; frame_end marks the byte
// that completes the frame, run_last the final byte produced by an item. A
// start while a frame is open, or data while idle, yields one error item and
// leaves the frame state alone. The front end takes one item per cycle into a
// two-entry command queue while it is not full; the back end drains one output
// byte per cycle while the output is taken, so data items sustain one item per
// cycle, a short header holds the back end for its two bytes and a long header
// for its nine, during which the front keeps accepting until the queue fills.
// An item's first byte is written into a queue entry at the accepting edge and
// reaches the output register when the back end takes that entry and the
// output can accept it. frame_length is taken modulo 2^LENGTH_WIDTH. No
// clearing pass after reset: ready rises on the first cycle out of reset.
module length_prefixed_frame_encoder_core #(
  parameter int LENGTH_WIDTH = lpfe_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  lpfe_in_if.sink     req,
  lpfe_out_if.source  rsp
);
  import lpfe_pkg::*;

  lpfe_push_t push_req;
  lpfe_cmd_t  head;
  logic       full;
  logic       head_valid;
  logic       pop;

  // Front: frame state and classification.
  lpfe_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .full     (full),
    .push_req (push_req)
  );

  // Decouples header expansion from intake.
  lpfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_req   (push_req),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back: byte sequencer and output register.
  lpfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the length-prefixed frame encoder core.
module tb_top;
  import lpfe_pkg::*;

  localparam int          LEN_W        = LENGTH_WIDTH_DEFAULT;
  localparam logic [63:0] LEN_MASK     = {64{1'b1}} >> (64 - LEN_W);
  localparam logic [63:0] SHORT_MAX    = 64'd255;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          RANDOM_ITEMS = 130;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst;

  lpfe_in_if  req_if ();
  lpfe_out_if rsp_if ();

  length_prefixed_frame_encoder_core #(
    .LENGTH_WIDTH(LEN_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #1 clk = ~clk;

  // Predictor state: mirrors the open frame and its remaining body length.
  logic         frame_open;
  logic [63:0]  body_left;
  lpfe_result_t encoded_q[$];

  // Random idling switches for each side.
  bit tx_gaps;
  bit rx_stalls;

  int unsigned cycles       = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned frames_begun = 0;
  int unsigned proto_errors = 0;
  int unsigned mismatches   = 0;

  function automatic void push_byte(input logic [7:0] b, input logic last,
                                    input logic fend, input logic [1:0] err);
    lpfe_result_t r;
    r.out_byte   = b;
    r.run_last   = last;
    r.frame_end  = fend;
    r.error_code = err;
    encoded_q.push_back(r);
  endfunction

  // Expected output bytes for one accepted item; updates the frame state.
  function automatic void encode_item(input logic op, input logic [63:0] len_in,
                                      input logic [7:0] data);
    logic [63:0] len;
    if (op == OP_START) begin
      if (frame_open) begin
        push_byte(8'h00, 1'b1, 1'b0, ERR_BUSY);
        proto_errors++;
        return;
      end
      len = len_in & LEN_MASK;
      if (len > SHORT_MAX) begin
        push_byte(FLAG_LONG, 1'b0, 1'b0, ERR_NONE);
        // length goes out most significant byte first
        for (int i = 0; i < LEN_BYTES; i++)
          push_byte(len[8 * (LEN_BYTES - 1 - i) +: 8], i == LEN_BYTES - 1, 1'b0, ERR_NONE);
      end else begin
        push_byte(FLAG_SHORT, 1'b0, 1'b0, ERR_NONE);
        push_byte(len[7:0], 1'b1, len == 0, ERR_NONE);
      end
      body_left  = len;
      frame_open = (len != 0);
      frames_begun++;
    end else begin
      if (!frame_open) begin
        push_byte(8'h00, 1'b1, 1'b0, ERR_IDLE);
        proto_errors++;
        return;
      end
      body_left = body_left - 1;
      push_byte(data, 1'b1, body_left == 0, ERR_NONE);
      if (body_left == 0)
        frame_open = 1'b0;
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(255, 0));
  endfunction

  // Drive one item, hold it until accepted, then predict its output.
  task automatic send_item(input logic op, input logic [63:0] len, input logic [7:0] data);
    int gap;
    gap = tx_gaps ? $urandom_range(9, 0) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.frame_length <= len;
    req_if.body_byte    <= data;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    encode_item(op, len, data);
    items_sent++;
  endtask

  // Sender holds off until every expected byte has come out.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Start plus body; noisy frames get stray starts mixed into the body.
  task automatic send_frame(input logic [63:0] len, input bit noisy);
    send_item(OP_START, len, rand8());
    for (longint unsigned k = 0; k < len; k++) begin
      if (noisy && $urandom_range(11, 0) == 0)
        send_item(OP_START, rand64(), rand8());
      send_item(OP_DATA, rand64(), rand8());
    end
  endtask

  task automatic test_idle_data();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_item(OP_DATA, 64'd0, 8'h00);
    send_item(OP_DATA, {64{1'b1}}, 8'hFF);
    send_item(OP_DATA, 64'd0, 8'h5A);
    wait_drained();
  endtask

  task automatic test_short_headers();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_item(OP_START, 64'd0, 8'hFF);     // zero-length: header only
    send_item(OP_DATA, 64'd0, 8'h11);      // still idle afterwards
    send_item(OP_START, 64'd1, 8'h00);
    send_item(OP_DATA, 64'd0, 8'hFF);
    send_item(OP_START, 64'd3, 8'h00);
    send_item(OP_START, 64'd7, 8'h00);     // rejected, frame stays open
    send_item(OP_DATA, 64'd0, 8'h00);
    send_item(OP_DATA, 64'd0, 8'hA5);
    send_item(OP_DATA, 64'd0, 8'h3C);
    wait_drained();
  endtask

  // Smallest length that takes the eight-byte header.
  task automatic test_shortest_long_frame();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    send_frame(SHORT_MAX + 1, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    logic [63:0] body_len;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      tx_gaps   = ($urandom_range(3, 0) != 0);
      rx_stalls = ($urandom_range(3, 0) != 0);
      if ($urandom_range(7, 0) == 0)
        send_item(OP_DATA, rand64(), rand8());
      body_len = ($urandom_range(9, 0) == 0) ? 64'($urandom_range(40, 17))
                                               : 64'($urandom_range(16, 0));
      send_frame(body_len, 1'b1);
      if ($urandom_range(9, 0) == 0)
        wait_drained();
    end
    wait_drained();
  endtask

  // Full-width length: frame never closes, so this runs last.
  task automatic test_max_length();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_item(OP_START, {64{1'b1}}, 8'h00);
    send_item(OP_START, 64'd0, 8'h00);
    send_item(OP_DATA, 64'd0, 8'h00);
    send_item(OP_DATA, 64'd0, 8'hFF);
    send_item(OP_START, {64{1'b1}}, 8'hFF);
    wait_drained();
  endtask

  // Output side: fresh stall draw for every item taken.
  initial begin : rsp_pacing
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = rx_stalls ? $urandom_range(9, 0) : 0;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : stream_check
    lpfe_result_t want;
    lpfe_result_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      got = '{rsp_if.out_byte, rsp_if.run_last, rsp_if.frame_end, rsp_if.error_code};
      if (encoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output: byte %h last %b end %b err %0d", $time,
                 got.out_byte, got.run_last, got.frame_end, got.error_code);
      end else begin
        want = encoded_q.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected byte %h last %b end %b err %0d, got byte %h last %b end %b err %0d",
                   $time, want.out_byte, want.run_last, want.frame_end, want.error_code,
                   got.out_byte, got.run_last, got.frame_end, got.error_code);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, encoded_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : run
    frame_open          = 1'b0;
    body_left           = '0;
    tx_gaps             = 1'b0;
    rx_stalls           = 1'b0;
    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.opcode       <= OP_START;
    req_if.frame_length <= '0;
    req_if.body_byte    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_idle_data();
    test_short_headers();
    test_shortest_long_frame();
    test_random_frames();
    test_max_length();

    $display("Sent %0d items (%0d frames opened, %0d rejected), checked %0d output bytes",
             items_sent, frames_begun, proto_errors, results_seen);
    $display("Run covered idle data, zero/short/long headers and full-width length");
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/lpfe_pkg.sv
sv/lpfe_in_if.sv
sv/lpfe_out_if.sv
sv/lpfe_front.sv
sv/lpfe_queue.sv
sv/lpfe_back.sv
sv/length_prefixed_frame_encoder_core.sv
bench/tb_top.sv
